/* hw/rtl/ccpr_pkg.sv */
// shared types and constants of the control change packet reporter
package ccpr_pkg;

  localparam int unsigned POT_CHANNELS_DEF    = 4;
  localparam int unsigned BUTTON_CHANNELS_DEF = 4;

  localparam int unsigned THRESH_W  = 12;
  localparam int unsigned TIMEOUT_W = 8;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PKT_BYTES = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [THRESH_W-1:0]  RESET_THRESHOLD = 12'd10;
  localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT   = 8'd100;

  localparam logic [BYTE_W-1:0]   CMD_POT         = 8'h50;  // 'P'
  localparam logic [BYTE_W-1:0]   CMD_BUTTON      = 8'h42;  // 'B'
  localparam logic [SAMPLE_W-1:0] LOW_NIBBLE_MASK = 12'h00F;

  typedef enum logic {
    KIND_POT    = 1'b0,
    KIND_BUTTON = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_TIMEOUT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                kind;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packet_byte;
    logic              last_byte;
  } out_t;

  // one memory word per pot channel
  typedef struct packed {
    logic [SAMPLE_W-1:0]  value;
    logic [TIMEOUT_W-1:0] timer;
  } pot_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] chan;
    logic [BYTE_W-1:0] data0;
    logic [BYTE_W-1:0] data1;
    logic [BYTE_W-1:0] sum;
  } pkt_t;

  // handshake between compute stage and serializer
  typedef struct packed {
    logic load;
    pkt_t pkt;
  } pkt_req_t;

endpackage

/* hw/rtl/ccpr_state_mem.sv */
// channel state memory with registered read, write forwarding and reset-to-zero valid bits
module ccpr_state_mem #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rd_q;
  logic             rd_vld_q;
  logic             fwd;

  assign fwd = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= fwd ? wr_data_i : mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= fwd || vld_q[rd_addr_i];
      end
    end
  end

  // never written entries read as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

`ifndef SYNTH
  a_fwd_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && wr_en_i && (wr_addr_i == rd_addr_i) |=> rd_data_o == $past(wr_data_i))
    else $error("write data not forwarded to read of same entry");
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd_en_i |=> $stable(rd_q) && $stable(rd_vld_q))
    else $error("read data changed without a read");
`endif

endmodule

/* hw/rtl/ccpr_packet_ser.sv */
// five-byte packet buffer that sends one byte per output request
module ccpr_packet_ser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccpr_pkg::pkt_req_t req_i,
  output logic              load_ok_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ccpr_pkg::out_t    out_data_o
);
  import ccpr_pkg::*;

  localparam int unsigned CntW = $clog2(PKT_BYTES);
  localparam logic [CntW-1:0] LastCnt = CntW'(PKT_BYTES - 1);

  logic [BYTE_W-1:0] bytes_q [PKT_BYTES];
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              take;
  logic              done;

  assign take      = busy_q && !out_stall_i;
  assign done      = take && (cnt_q == LastCnt);
  assign load_ok_o = !busy_q || done;

  always_ff @(posedge clk_i) begin
    if (req_i.load && load_ok_o) begin
      bytes_q[0] <= req_i.pkt.cmd;
      bytes_q[1] <= req_i.pkt.chan;
      bytes_q[2] <= req_i.pkt.data0;
      bytes_q[3] <= req_i.pkt.data1;
      bytes_q[4] <= req_i.pkt.sum;
    end else if (take) begin
      for (int i = 0; i < PKT_BYTES - 1; i++) begin
        bytes_q[i] <= bytes_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.load && load_ok_o) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (take) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign out_valid_o            = busy_q;
  assign out_data_o.packet_byte = bytes_q[0];
  assign out_data_o.last_byte   = (cnt_q == LastCnt);

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastCnt)
    else $error("byte counter past end of packet");
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !req_i.load |=> !out_valid_o)
    else $error("serializer still busy after last byte");
`endif

endmodule

/* hw/rtl/control_change_packet_reporter_unit.sv */
// Control change packet reporter: pot deadband and button edge detection
// with five-byte packets (command, channel, data0, data1, 8-bit sum).
// Input channel: in_valid_i / in_stall_o carrying kind, channel, sample.
// Output channel: out_valid_o / out_stall_i carrying one packet byte per
// request, last_byte set on the checksum byte.
// Configuration: cfg_we_i writes cfg_data_i into the register cfg_idx_i
// (0 change threshold, 1 idle timeout); write only while the block is idle.
// Flow: a sample is read from the state memory at its accept edge, is
// evaluated in the next cycle and its packet loads into the serializer
// once load_ok allows it; the serializer register then drives the first byte.
// Throughput: samples that report nothing are taken one per cycle while no
// reporting sample waits in the compute stage; a reporting sample waits there
// until the byte serializer is idle or takes the last byte of its packet.
// Back-to-back samples on one channel see each other's updates through
// write forwarding in the state memories.
// Reset: threshold 10, timeout 100, all pot values, timers and button
// levels read as zero. A stalled receiver holds the current byte; once the
// compute stage holds a packet it cannot hand over, in_stall_o rises.
module control_change_packet_reporter_unit #(
  parameter int unsigned PotChannels    = ccpr_pkg::POT_CHANNELS_DEF,
  parameter int unsigned ButtonChannels = ccpr_pkg::BUTTON_CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ccpr_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ccpr_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ccpr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ccpr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ccpr_pkg::*;

  localparam int unsigned PotAw = (PotChannels > 1) ? $clog2(PotChannels) : 1;
  localparam int unsigned BtnAw = (ButtonChannels > 1) ? $clog2(ButtonChannels) : 1;
  localparam int unsigned PotW  = $bits(pot_word_t);

  logic [THRESH_W-1:0]  thresh_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  logic in_accept;
  logic s1_valid_q;
  in_t  s1_q;
  logic s1_inrange_q;
  logic s1_fire;
  logic in_inrange;

  logic [PotW-1:0] pot_rd;
  logic [PotW-1:0] pot_wr;
  logic            pot_we;
  logic            btn_rd;
  logic            btn_wr;
  logic            btn_we;

  pot_word_t            pot_old;
  pot_word_t            pot_new;
  logic [SAMPLE_W-1:0]  diff;
  logic                 moved;
  logic                 level;
  logic                 emit;
  logic [BYTE_W-1:0]    b_cmd;
  logic [BYTE_W-1:0]    b_chan;
  logic [BYTE_W-1:0]    b_d0;
  logic [BYTE_W-1:0]    b_d1;
  pkt_req_t             req;
  logic                 load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= RESET_THRESHOLD;
      timeout_q <= RESET_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thresh_q  <= cfg_data_i;
        REG_TIMEOUT:   timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_inrange = (in_data_i.kind == KIND_POT)
                    ? (int'(in_data_i.channel) < PotChannels)
                    : (int'(in_data_i.channel) < ButtonChannels);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q         <= in_data_i;
      s1_inrange_q <= in_inrange;
    end
  end

  ccpr_state_mem #(
    .Depth(PotChannels),
    .Width(PotW)
  ) u_pot_mem (
    .clk_i,
    .rst_ni,
    .rd_en_i  (in_accept),
    .rd_addr_i(PotAw'(in_data_i.channel)),
    .rd_data_o(pot_rd),
    .wr_en_i  (pot_we),
    .wr_addr_i(PotAw'(s1_q.channel)),
    .wr_data_i(pot_wr)
  );

  ccpr_state_mem #(
    .Depth(ButtonChannels),
    .Width(1)
  ) u_btn_mem (
    .clk_i,
    .rst_ni,
    .rd_en_i  (in_accept),
    .rd_addr_i(BtnAw'(in_data_i.channel)),
    .rd_data_o(btn_rd),
    .wr_en_i  (btn_we),
    .wr_addr_i(BtnAw'(s1_q.channel)),
    .wr_data_i(btn_wr)
  );

  // evaluate the sample against its channel state
  always_comb begin
    pot_old = pot_word_t'(pot_rd);
    diff    = (s1_q.sample_value >= pot_old.value) ? s1_q.sample_value - pot_old.value
                                                   : pot_old.value - s1_q.sample_value;
    moved   = diff > thresh_q;
    level   = |s1_q.sample_value;
    pot_new = pot_old;
    if (moved) begin
      pot_new.value = s1_q.sample_value;
      pot_new.timer = timeout_q;
    end else if (pot_old.timer > TIMEOUT_W'(1)) begin
      pot_new.timer = pot_old.timer - 1'b1;
    end
    b_chan = BYTE_W'(s1_q.channel);
    if (s1_q.kind == KIND_POT) begin
      emit  = s1_inrange_q && (pot_old.timer > TIMEOUT_W'(1));
      b_cmd = CMD_POT;
      b_d0  = BYTE_W'(s1_q.sample_value & LOW_NIBBLE_MASK);
      b_d1  = s1_q.sample_value[SAMPLE_W-1:4];
    end else begin
      emit  = s1_inrange_q && (level != btn_rd);
      b_cmd = CMD_BUTTON;
      b_d0  = BYTE_W'(level);
      b_d1  = '0;
    end
  end

  assign s1_fire = s1_valid_q && (!emit || load_ok);
  assign pot_we  = s1_fire && s1_inrange_q && (s1_q.kind == KIND_POT);
  assign pot_wr  = pot_new;
  assign btn_we  = s1_fire && s1_inrange_q && (s1_q.kind == KIND_BUTTON);
  assign btn_wr  = level;

  assign in_stall_o = s1_valid_q && !s1_fire;

  assign req.load      = s1_valid_q && emit;
  assign req.pkt.cmd   = b_cmd;
  assign req.pkt.chan  = b_chan;
  assign req.pkt.data0 = b_d0;
  assign req.pkt.data1 = b_d1;
  assign req.pkt.sum   = b_cmd + b_chan + b_d0 + b_d1;

  ccpr_packet_ser u_ser (
    .clk_i,
    .rst_ni,
    .req_i      (req),
    .load_ok_o  (load_ok),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

`ifndef SYNTH
  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q && $stable(s1_q))
    else $error("stalled item lost from compute stage");
  a_no_write_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pot_we || btn_we) |-> s1_inrange_q && s1_valid_q)
    else $error("state written for an ignored channel");
`endif

endmodule
